// ----- hdl/ealfr_pkg.sv -----
// Package: shared types, control characters and phase codes for the ENQ/ACK frame receiver.
package ealfr_pkg;

    localparam int LEN_WIDTH_DEFAULT = 16;
    localparam int BAD_WIDTH         = 16;

    localparam logic [7:0] CHAR_SOH   = 8'd1;
    localparam logic [7:0] CHAR_SOX   = 8'd2;
    localparam logic [7:0] CHAR_ETX   = 8'd3;
    localparam logic [7:0] CHAR_EOT   = 8'd4;
    localparam logic [7:0] CHAR_ENQ   = 8'd5;
    localparam logic [7:0] CHAR_ACK   = 8'd6;
    localparam logic [7:0] CHAR_CTL_TOP = 8'd31;
    localparam logic [7:0] CHAR_DEL   = 8'd127;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    typedef enum logic [2:0] {
        PH_WAIT_ENQ = 3'd0,
        PH_WAIT_SOH = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_TRAILER  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_OK       = 2'd1,
        ST_ZERO_LEN = 2'd2,
        ST_GARBAGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic                 send_ack;
        logic                 payload_valid;
        logic [7:0]           payload_byte;
        logic                 payload_end;
        logic [BAD_WIDTH-1:0] bad_count;
        status_t              frame_status;
    } result_t;

endpackage

// ----- hdl/enq_ack_length_framed_receiver_core.sv -----
// Top level: ENQ/ACK length-framed serial receiver core.
// Result path: input register, then result register.
// Throughput: one byte per cycle unless a stalled consumer holds the result register;
// the phase machine and counters update in a single step.
// Stalls: input stall follows a held result register whose consumer stalls.
// Reset: asynchronous, active low; empties both registers and returns to waiting for ENQ.
module enq_ack_length_framed_receiver_core #(
    parameter int LEN_WIDTH = ealfr_pkg::LEN_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        send_ack,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic        payload_end,
    output logic [15:0] bad_count,
    output logic [1:0]  frame_status
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         rx_reg;
    logic               load_ready;
    logic               advance;
    ealfr_pkg::result_t step_result;
    ealfr_pkg::result_t out_result;

    assign advance       = in_valid_reg && load_ready;
    assign in_stall      = in_valid_reg && !load_ready;
    assign in_valid_next = in_stall ? in_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rx_reg <= rx_byte;
        end
    end

    ealfr_deframer #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (rx_reg),
        .result  (step_result)
    );

    ealfr_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (in_valid_reg),
        .load_result (step_result),
        .load_ready  (load_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (out_result)
    );

    assign send_ack      = out_result.send_ack;
    assign payload_valid = out_result.payload_valid;
    assign payload_byte  = out_result.payload_byte;
    assign payload_end   = out_result.payload_end;
    assign bad_count     = out_result.bad_count;
    assign frame_status  = out_result.frame_status;

endmodule

// ----- hdl/ealfr_deframer.sv -----
// Deframer: phase machine and frame counters, one received byte per step.
module ealfr_deframer #(
    parameter int LEN_WIDTH = ealfr_pkg::LEN_WIDTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output ealfr_pkg::result_t  result
);

    localparam int BW = ealfr_pkg::BAD_WIDTH;

    ealfr_pkg::phase_t     phase_reg, phase_next;
    logic [LEN_WIDTH-1:0]  length_reg, length_next;
    logic                  closed_reg, closed_next;
    logic [LEN_WIDTH-1:0]  count_reg, count_next;
    logic [BW-1:0]         bad_reg, bad_next;

    logic [LEN_WIDTH+3:0]  length_wide;
    logic [LEN_WIDTH:0]    count_inc;
    logic                  is_digit;
    logic                  is_print;

    assign is_digit    = rx_byte inside {[ealfr_pkg::CHAR_ZERO:ealfr_pkg::CHAR_NINE]};
    assign is_print    = (rx_byte > ealfr_pkg::CHAR_CTL_TOP) && (rx_byte < ealfr_pkg::CHAR_DEL);
    assign length_wide = ({4'd0, length_reg} << 3) + ({4'd0, length_reg} << 1)
                       + {{(LEN_WIDTH-4){1'b0}}, (rx_byte - ealfr_pkg::CHAR_ZERO)};
    assign count_inc   = {1'b0, count_reg} + {{LEN_WIDTH{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        closed_next = closed_reg;
        count_next  = count_reg;
        bad_next    = bad_reg;
        case (phase_reg)
            ealfr_pkg::PH_WAIT_ENQ:
            begin
                if (rx_byte == ealfr_pkg::CHAR_ENQ)
                begin
                    phase_next = ealfr_pkg::PH_WAIT_SOH;
                end
            end
            ealfr_pkg::PH_WAIT_SOH:
            begin
                if (rx_byte == ealfr_pkg::CHAR_SOH)
                begin
                    length_next = '0;
                    closed_next = 1'b0;
                    count_next  = '0;
                    bad_next    = '0;
                    phase_next  = ealfr_pkg::PH_LENGTH;
                end
            end
            ealfr_pkg::PH_LENGTH:
            begin
                if (rx_byte == ealfr_pkg::CHAR_SOX)
                begin
                    if (length_reg == '0)
                    begin
                        phase_next = ealfr_pkg::PH_WAIT_ENQ;
                    end
                    else
                    begin
                        phase_next = ealfr_pkg::PH_PAYLOAD;
                    end
                end
                else if (!closed_reg)
                begin
                    if (is_digit)
                    begin
                        if (|length_wide[LEN_WIDTH+3:LEN_WIDTH])
                        begin
                            length_next = '1;
                        end
                        else
                        begin
                            length_next = length_wide[LEN_WIDTH-1:0];
                        end
                    end
                    else
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            ealfr_pkg::PH_PAYLOAD:
            begin
                if (rx_byte == ealfr_pkg::CHAR_ETX)
                begin
                    phase_next = ealfr_pkg::PH_TRAILER;
                end
                else
                begin
                    if (!is_print && (bad_reg != '1))
                    begin
                        bad_next = bad_reg + {{(BW-1){1'b0}}, 1'b1};
                    end
                    count_next = count_inc[LEN_WIDTH-1:0];
                    if (count_inc >= {1'b0, length_reg})
                    begin
                        phase_next = ealfr_pkg::PH_TRAILER;
                    end
                end
            end
            ealfr_pkg::PH_TRAILER:
            begin
                if (rx_byte != ealfr_pkg::CHAR_ETX)
                begin
                    phase_next = ealfr_pkg::PH_WAIT_ENQ;
                end
            end
            default:
            begin
                phase_next = ealfr_pkg::PH_WAIT_ENQ;
            end
        endcase
    end

    always_comb
    begin
        result               = '0;
        result.frame_status  = ealfr_pkg::ST_NONE;
        result.bad_count     = bad_next;
        case (phase_reg)
            ealfr_pkg::PH_WAIT_ENQ:
            begin
                result.send_ack = (rx_byte == ealfr_pkg::CHAR_ENQ);
            end
            ealfr_pkg::PH_LENGTH:
            begin
                if ((rx_byte == ealfr_pkg::CHAR_SOX) && (length_reg == '0))
                begin
                    result.frame_status = ealfr_pkg::ST_ZERO_LEN;
                end
            end
            ealfr_pkg::PH_PAYLOAD:
            begin
                if (rx_byte == ealfr_pkg::CHAR_ETX)
                begin
                    result.payload_end = 1'b1;
                end
                else
                begin
                    result.payload_valid = is_print;
                    result.payload_byte  = is_print ? rx_byte : 8'd0;
                    result.payload_end   = (count_inc >= {1'b0, length_reg});
                end
            end
            ealfr_pkg::PH_TRAILER:
            begin
                if (rx_byte == ealfr_pkg::CHAR_EOT)
                begin
                    result.frame_status = ealfr_pkg::ST_OK;
                end
                else if (rx_byte != ealfr_pkg::CHAR_ETX)
                begin
                    result.frame_status = ealfr_pkg::ST_GARBAGE;
                end
            end
            default:
            begin
                result.send_ack = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ealfr_pkg::PH_WAIT_ENQ;
            length_reg <= '0;
            closed_reg <= 1'b0;
            count_reg  <= '0;
            bad_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            closed_reg <= closed_next;
            count_reg  <= count_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

// ----- hdl/ealfr_out_reg.sv -----
// Result register: holds one result transaction until the consumer takes it.
module ealfr_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    input  ealfr_pkg::result_t  load_result,
    output logic                load_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output ealfr_pkg::result_t  result
);

    logic               valid_reg, valid_next;
    ealfr_pkg::result_t result_reg;

    assign load_ready = !valid_reg || !out_stall;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule
